@@ rtl/core/closest_pair_distance_top_defines.svh @@
// Assertion macros shared by the closest-pair distance checker.
`ifndef CLOSEST_PAIR_DISTANCE_TOP_DEFINES_SVH
`define CLOSEST_PAIR_DISTANCE_TOP_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define CPD_ASSERT_SAME(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |-> (cons)) \
		else $error(msg);

// The condition must hold in the cycle after the trigger.
`define CPD_ASSERT_NEXT(lbl, ant, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ant) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cpd_pkg.sv @@
// Shared types and constants of the closest-pair distance block.
`default_nettype none

package cpd_pkg;

	localparam int COORD_W = 16;
	localparam int SQ_W    = 34;
	localparam int DIST_W  = 31;
	localparam int ROOT_W  = 17;
	localparam int STEP_W  = 5;
	localparam int REM_W   = 20;

	localparam logic [DIST_W-1:0] NO_PAIR_VALUE = 31'd2000000000;
	localparam logic [SQ_W-1:0]   SQ_ALL_ONES   = {SQ_W{1'b1}};

	// One point travelling down the cell row, with the smallest squared
	// distance it has met so far.
	typedef struct packed {
		logic                      valid;
		logic                      last;
		logic                      cmp;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [SQ_W-1:0]           dmin;
	} wave_t;

endpackage

`default_nettype wire

@@ rtl/core/cpd_cell.sv @@
// One cell of the point row: holds one stored point and compares passing points.
`default_nettype none

module cpd_cell #(
	parameter int IDX_W   = 9,
	parameter int CELL_ID = 0
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  cpd_pkg::wave_t       wave_in,
	input  wire [IDX_W-1:0]      idx_in,
	output cpd_pkg::wave_t       wave_out,
	output logic [IDX_W-1:0]     idx_out
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

	logic signed [cpd_pkg::COORD_W-1:0] px_q;
	logic signed [cpd_pkg::COORD_W-1:0] py_q;

	logic                       valid_s1;
	cpd_pkg::wave_t             wave_s1;
	logic [IDX_W-1:0]           idx_s1;

	logic                       hit;
	logic                       store_en;
	logic signed [cpd_pkg::COORD_W:0] dx;
	logic signed [cpd_pkg::COORD_W:0] dy;
	logic signed [cpd_pkg::SQ_W-1:0]  sx;
	logic signed [cpd_pkg::SQ_W-1:0]  sy;
	logic [cpd_pkg::SQ_W-1:0]         dsq;
	cpd_pkg::wave_t                   wave_nxt;

	// A point is compared only against cells filled by earlier points of the set.
	assign hit      = wave_in.valid && wave_in.cmp && (idx_in > MY_IDX);
	assign store_en = wave_in.valid && wave_in.cmp && (idx_in == MY_IDX);

	assign dx  = {wave_in.x[cpd_pkg::COORD_W-1], wave_in.x} - {px_q[cpd_pkg::COORD_W-1], px_q};
	assign dy  = {wave_in.y[cpd_pkg::COORD_W-1], wave_in.y} - {py_q[cpd_pkg::COORD_W-1], py_q};
	assign sx  = cpd_pkg::SQ_W'(dx * dx);
	assign sy  = cpd_pkg::SQ_W'(dy * dy);
	assign dsq = $unsigned(sx) + $unsigned(sy);

	always_comb begin
		wave_nxt = wave_in;
		if (hit && (dsq < wave_in.dmin)) begin
			wave_nxt.dmin = dsq;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= wave_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		wave_s1 <= wave_nxt;
		idx_s1  <= idx_in;
		if (store_en) begin
			px_q <= wave_in.x;
			py_q <= wave_in.y;
		end
	end

	always_comb begin
		wave_out       = wave_s1;
		wave_out.valid = valid_s1;
	end

	assign idx_out = idx_s1;

endmodule

`default_nettype wire

@@ rtl/core/cpd_isqrt.sv @@
// Iterative integer square root, one result bit per cycle.
`default_nettype none

module cpd_isqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	input  wire [cpd_pkg::SQ_W-1:0]      value,
	output logic                         done,
	output logic [cpd_pkg::ROOT_W-1:0]   root
);

	logic                          run_q;
	logic                          done_q;
	logic [cpd_pkg::STEP_W-1:0]    step_q;
	logic [cpd_pkg::SQ_W-1:0]      v_q;
	logic [cpd_pkg::REM_W-1:0]     rem_q;
	logic [cpd_pkg::ROOT_W-1:0]    root_q;

	logic [cpd_pkg::REM_W-1:0]     rem_next;
	logic [cpd_pkg::REM_W-1:0]     trial;
	logic                          ge;

	// Bring down the next two bits of the radicand and try a one digit.
	assign rem_next = {rem_q[cpd_pkg::REM_W-3:0], v_q[cpd_pkg::SQ_W-1 -: 2]};
	assign trial    = cpd_pkg::REM_W'({root_q, 2'b01});
	assign ge       = rem_next >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q  <= 1'b1;
				step_q <= cpd_pkg::STEP_W'(cpd_pkg::ROOT_W - 1);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= value;
			rem_q  <= '0;
			root_q <= '0;
		end else if (run_q) begin
			v_q    <= v_q << 2;
			rem_q  <= ge ? (rem_next - trial) : rem_next;
			root_q <= {root_q[cpd_pkg::ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

`default_nettype wire

@@ rtl/core/closest_pair_distance_top.sv @@
// Closest-pair distance block: a row of point cells feeding a square-root unit.
`default_nettype none

// Points of a set enter one beat per cycle and are never stalled until the
// beat flagged last_point is taken. Each point walks down a row of
// MAX_POINTS cells, one cell per cycle, and is compared in each cell against
// the point that cell holds; point n of a set, counted from zero, settles
// in cell n. Points past MAX_POINTS are dropped and raise overflow. After
// the last beat the input is stalled until the result beat is taken. The
// last beat leaves the row and starts the square-root unit, which runs the
// 17 steps of the bit-serial square root; its root then goes through one
// output register. With fewer than two points the result is 2000000000
// with no_pair set.

module closest_pair_distance_top #(
	parameter int MAX_POINTS = 256
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   in_valid,
	output logic                                  in_stall,
	input  wire signed [cpd_pkg::COORD_W-1:0]     point_x,
	input  wire signed [cpd_pkg::COORD_W-1:0]     point_y,
	input  wire                                   last_point,
	output logic                                  out_valid,
	input  wire                                   out_stall,
	output logic [cpd_pkg::DIST_W-1:0]            min_distance,
	output logic                                  no_pair,
	output logic                                  overflow
);

	localparam int IDX_W = $clog2(MAX_POINTS + 1);
	localparam logic [IDX_W-1:0] FULL_COUNT = IDX_W'(MAX_POINTS);

	cpd_pkg::wave_t          chain_w   [0:MAX_POINTS];
	logic [IDX_W-1:0]        chain_idx [0:MAX_POINTS];

	logic [IDX_W-1:0]        count_q;
	logic                    dropped_q;
	logic                    busy_q;
	logic                    no_pair_q;
	logic                    overflow_q;
	logic [cpd_pkg::SQ_W-1:0] best_q;
	logic                    out_valid_q;
	logic [cpd_pkg::DIST_W-1:0] min_dist_q;

	logic                    in_acc;
	logic                    out_acc;
	logic                    full;
	logic [IDX_W-1:0]        final_count;
	cpd_pkg::wave_t          w_end;
	logic [cpd_pkg::SQ_W-1:0] merged;
	logic                    sqrt_start;
	logic                    sqrt_done;
	logic [cpd_pkg::ROOT_W-1:0] sqrt_root;

	assign in_acc      = in_valid && !in_stall;
	assign out_acc     = out_valid_q && !out_stall;
	assign full        = count_q == FULL_COUNT;
	assign final_count = full ? count_q : count_q + 1'b1;

	always_comb begin
		chain_w[0].valid = in_acc;
		chain_w[0].last  = last_point;
		chain_w[0].cmp   = !full;
		chain_w[0].x     = point_x;
		chain_w[0].y     = point_y;
		chain_w[0].dmin  = cpd_pkg::SQ_ALL_ONES;
		chain_idx[0]     = count_q;
	end

	for (genvar k = 0; k < MAX_POINTS; k++) begin : g_cell
		cpd_cell #(
			.IDX_W   (IDX_W),
			.CELL_ID (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.wave_in  (chain_w[k]),
			.idx_in   (chain_idx[k]),
			.wave_out (chain_w[k+1]),
			.idx_out  (chain_idx[k+1])
		);
	end

	assign w_end      = chain_w[MAX_POINTS];
	assign merged     = (w_end.dmin < best_q) ? w_end.dmin : best_q;
	assign sqrt_start = w_end.valid && w_end.last;

	cpd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.value  (merged),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			dropped_q   <= 1'b0;
			busy_q      <= 1'b0;
			best_q      <= cpd_pkg::SQ_ALL_ONES;
			out_valid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (last_point) begin
					count_q   <= '0;
					dropped_q <= 1'b0;
					busy_q    <= 1'b1;
				end else begin
					count_q   <= final_count;
					dropped_q <= dropped_q | full;
				end
			end
			if (w_end.valid) begin
				best_q <= w_end.last ? cpd_pkg::SQ_ALL_ONES : merged;
			end
			if (sqrt_done) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
				busy_q      <= 1'b0;
			end
		end
	end

	// The set summary is captured with the last beat and held until the result leaves.
	always_ff @(posedge clk) begin
		if (in_acc && last_point) begin
			no_pair_q  <= final_count < IDX_W'(2);
			overflow_q <= dropped_q | full;
		end
		if (sqrt_done) begin
			min_dist_q <= no_pair_q ? cpd_pkg::NO_PAIR_VALUE : cpd_pkg::DIST_W'(sqrt_root);
		end
	end

	assign in_stall     = busy_q;
	assign out_valid    = out_valid_q;
	assign min_distance = min_dist_q;
	assign no_pair      = no_pair_q;
	assign overflow     = overflow_q;

endmodule

`default_nettype wire

@@ rtl/core/cpd_checker.sv @@
// Port-level checks of the closest-pair distance block and their binding.
`default_nettype none
`include "closest_pair_distance_top_defines.svh"

module cpd_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          in_valid,
	input wire                          in_stall,
	input wire                          last_point,
	input wire                          out_valid,
	input wire                          out_stall,
	input wire [cpd_pkg::DIST_W-1:0]    min_distance,
	input wire                          no_pair
);

	`CPD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(min_distance), "result beat changed while stalled")

	`CPD_ASSERT_SAME(a_no_pair_value, out_valid && no_pair, min_distance == cpd_pkg::NO_PAIR_VALUE, "no_pair result without the sentinel distance")

	`CPD_ASSERT_SAME(a_stall_while_result, out_valid, in_stall, "input open while a result is pending")

	`CPD_ASSERT_NEXT(a_stall_after_last, in_valid && !in_stall && last_point, in_stall, "input not stalled after the last point")

endmodule

bind closest_pair_distance_top cpd_checker u_cpd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last_point   (last_point),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.min_distance (min_distance),
	.no_pair      (no_pair)
);

`default_nettype wire
